FILE: rtl/sha256_stream_hasher_core_assert.svh
// Assertion macros shared by the SHA-256 stream hasher RTL.
`ifndef SHA256_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_STREAM_HASHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHASH_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SHASH_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/shash_pkg.sv
// Types and constants shared by the SHA-256 stream hasher modules.
`default_nettype none

package shash_pkg;

    localparam int BlockBytes = 64;
    localparam int FillBits   = $clog2(BlockBytes);
    localparam int CountBits  = 61;
    localparam int Rounds     = 64;
    localparam int RoundBits  = $clog2(Rounds);
    localparam int HashWords  = 8;
    localparam int WordBits   = $clog2(HashWords);

    // first byte position reserved for the 64-bit length field
    localparam logic [FillBits-1:0] LenStart = FillBits'(BlockBytes - 8);
    localparam logic [FillBits-1:0] FillLast = FillBits'(BlockBytes - 1);
    localparam logic [7:0]          PadByte  = 8'h80;

    localparam logic [31:0] RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] InitHash [HashWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // source of the byte shifted into the block buffer
    typedef enum logic [1:0] {
        SEL_IN,
        SEL_PAD80,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    // controller -> datapath
    typedef struct packed {
        logic                  shift_byte;
        byte_sel_t             byte_sel;
        logic                  count_inc;
        logic                  load_work;
        logic                  round_en;
        logic [RoundBits-1:0]  round_idx;
        logic                  hash_add;
        logic                  hash_init;
        logic [WordBits-1:0]   out_idx;
    } shash_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [FillBits-1:0] fill;
    } shash_sts_t;

endpackage

`default_nettype wire

FILE: rtl/shash_datapath.sv
// SHA-256 datapath: block buffer / schedule window, round unit, hash and length state.
`default_nettype none

module shash_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire shash_pkg::shash_cmd_t               cmd,
    input  wire logic [7:0]                          byte_in,
    output shash_pkg::shash_sts_t                    sts,
    output logic [31:0]                              digest_word,
    output logic                                     length_overflow
);

    localparam int WinBits = 32 * 16;

    logic [WinBits-1:0]                   win_reg;
    logic [31:0]                          work_reg [shash_pkg::HashWords];
    logic [31:0]                          hash_reg [shash_pkg::HashWords];
    logic [shash_pkg::FillBits-1:0]       fill_reg;
    logic [shash_pkg::CountBits-1:0]      count_reg;
    logic                                 ovf_reg;

    logic [7:0]  byte_mux;
    logic [63:0] len_bits;
    logic [31:0] w_cur;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    // window word j sits at [WinBits-1-32j -: 32]; word 0 is W[t]
    function automatic logic [31:0] win_word(input logic [WinBits-1:0] v, input int j);
        return v[WinBits-1-32*j -: 32];
    endfunction

    assign len_bits = {count_reg, 3'b000};

    always_comb begin
        case (cmd.byte_sel)
            shash_pkg::SEL_IN:    byte_mux = byte_in;
            shash_pkg::SEL_PAD80: byte_mux = shash_pkg::PadByte;
            shash_pkg::SEL_ZERO:  byte_mux = 8'h00;
            shash_pkg::SEL_LEN:   byte_mux = 8'(len_bits >> {~fill_reg[2:0], 3'b000});
            default:              byte_mux = 8'h00;
        endcase
    end

    always_comb begin
        w_cur = win_word(win_reg, 0);
        w_new = ssig1(win_word(win_reg, 14)) + win_word(win_reg, 9)
              + ssig0(win_word(win_reg, 1)) + w_cur;
        t1 = work_reg[7] + bsig1(work_reg[4])
           + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
           + shash_pkg::RoundK[cmd.round_idx] + w_cur;
        t2 = bsig0(work_reg[0])
           + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
              ^ (work_reg[1] & work_reg[2]));
    end

    // payload: window and working variables
    always_ff @(posedge aclk) begin
        if (cmd.shift_byte) begin
            win_reg <= {win_reg[WinBits-9:0], byte_mux};
        end else if (cmd.round_en) begin
            win_reg <= {win_reg[WinBits-33:0], w_new};
        end
        if (cmd.load_work) begin
            work_reg <= hash_reg;
        end else if (cmd.round_en) begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    // message state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg  <= shash_pkg::InitHash;
            fill_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            if (cmd.shift_byte) begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.hash_init) begin
                hash_reg  <= shash_pkg::InitHash;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                if (cmd.hash_add) begin
                    for (int i = 0; i < shash_pkg::HashWords; i++) begin
                        hash_reg[i] <= hash_reg[i] + work_reg[i];
                    end
                end
                if (cmd.count_inc) begin
                    if (&count_reg) begin
                        ovf_reg <= 1'b1;   // saturate
                    end else begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign sts.fill        = fill_reg;
    assign digest_word     = hash_reg[cmd.out_idx];
    assign length_overflow = ovf_reg;

endmodule

`default_nettype wire

FILE: rtl/shash_ctrl.sv
// SHA-256 controller: absorb, padding, round sequencing and digest readout.
`default_nettype none

module shash_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic                      s_tlast,
    input  wire logic                      s_tuser,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic                           m_tlast,
    input  wire shash_pkg::shash_sts_t     sts,
    output shash_pkg::shash_cmd_t          cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    state_t                            state_reg, state_next;
    logic [shash_pkg::RoundBits-1:0]   rnd_reg, rnd_next;
    logic [shash_pkg::WordBits-1:0]    oidx_reg, oidx_next;
    logic                              pad80_reg, pad80_next;
    logic                              len_ok_reg, len_ok_next;
    logic                              fin_reg, fin_next;
    logic                              last_blk_reg, last_blk_next;
    logic                              len_ok_cur;

    always_comb begin
        state_next    = state_reg;
        rnd_next      = rnd_reg;
        oidx_next     = oidx_reg;
        pad80_next    = pad80_reg;
        len_ok_next   = len_ok_reg;
        fin_next      = fin_reg;
        last_blk_next = last_blk_reg;
        cmd           = '0;
        cmd.byte_sel  = shash_pkg::SEL_IN;
        cmd.round_idx = rnd_reg;
        cmd.out_idx   = oidx_reg;
        // length fits in this block once 0x80 landed before the length field
        len_ok_cur    = pad80_reg ? (sts.fill < shash_pkg::LenStart) : len_ok_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        cmd.shift_byte = 1'b1;
                        cmd.count_inc  = 1'b1;
                    end
                    fin_next   = s_tlast;
                    pad80_next = 1'b1;
                    if (s_tuser && sts.fill == shash_pkg::FillLast) begin
                        cmd.load_work = 1'b1;
                        last_blk_next = 1'b0;
                        state_next    = ST_ROUND;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.shift_byte = 1'b1;
                if (pad80_reg) begin
                    cmd.byte_sel = shash_pkg::SEL_PAD80;
                    pad80_next   = 1'b0;
                    len_ok_next  = len_ok_cur;
                end else if (len_ok_reg && sts.fill >= shash_pkg::LenStart) begin
                    cmd.byte_sel = shash_pkg::SEL_LEN;
                end else begin
                    cmd.byte_sel = shash_pkg::SEL_ZERO;
                end
                if (sts.fill == shash_pkg::FillLast) begin
                    cmd.load_work = 1'b1;
                    last_blk_next = len_ok_cur;
                    len_ok_next   = 1'b1;   // a following block always has room
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                rnd_next     = rnd_reg + 1'b1;
                if (&rnd_reg) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.hash_add = 1'b1;
                if (last_blk_reg) begin
                    oidx_next  = '0;
                    state_next = ST_OUT;
                end else if (fin_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    oidx_next = oidx_reg + 1'b1;
                    if (&oidx_reg) begin
                        cmd.hash_init = 1'b1;
                        fin_next      = 1'b0;
                        last_blk_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rnd_reg      <= '0;
            oidx_reg     <= '0;
            pad80_reg    <= 1'b0;
            len_ok_reg   <= 1'b0;
            fin_reg      <= 1'b0;
            last_blk_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rnd_reg      <= rnd_next;
            oidx_reg     <= oidx_next;
            pad80_reg    <= pad80_next;
            len_ok_reg   <= len_ok_next;
            fin_reg      <= fin_next;
            last_blk_reg <= last_blk_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast  = (state_reg == ST_OUT) && (&oidx_reg);

endmodule

`default_nettype wire

FILE: rtl/sha256_stream_hasher_core.sv
// Top level of the SHA-256 stream hasher: controller plus datapath.
`default_nettype none
// Usage:
//   Slave channel: one transfer per message byte. s_tdata[7:0] is the byte,
//   s_tuser says the byte is part of the message, s_tlast ends the message.
//   A transfer with s_tlast and no byte finishes the message as it stands
//   (an empty message hashes to the empty-string digest).
//   Master channel: eight transfers per message, digest word 0 (most
//   significant) first; m_tlast marks word 7, m_tuser flags a message
//   longer than 2^61-1 bytes.
// Timing:
//   The byte that completes a 64-byte block stalls the input for its 64
//   rounds through the single round unit plus the hash update. On end of
//   message with n bytes in the buffer, padding shifts in 64-n bytes
//   (n <= 55) or 128-n bytes (n >= 56), one per cycle, each block is then
//   compressed the same way, then the digest is offered.
//   s_tready is high only while no message work or digest is pending.
// Reset: aresetn (synchronous, active low) loads the initial hash values and
//   clears the byte count, fill count and overflow flag.
// Stalls: the digest word is held on m_tdata while m_tready is low; the
//   state is reinitialized after the word 7 transfer.

`include "sha256_stream_hasher_core_assert.svh"

module sha256_stream_hasher_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] has_byte
    input  wire logic        s_tlast,   // end_of_message
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic             m_tuser,   // [0] length_overflow
    output logic             m_tlast    // last_word
);

    shash_pkg::shash_cmd_t cmd;
    shash_pkg::shash_sts_t sts;
    logic [31:0]           digest_word;

    shash_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    shash_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .byte_in         (s_tdata),
        .sts             (sts),
        .digest_word     (digest_word),
        .length_overflow (m_tuser)
    );

    assign m_tdata = {5'b00000, cmd.out_idx, digest_word};

    // input side and digest side are never open together
    `SHASH_ASSERT_IMP(a_no_overlap, aclk, aresetn, 1'b1, !(s_tready && m_tvalid),
        "input accepted while digest pending")

    // end of message always blocks input for padding/compression
    `SHASH_ASSERT_NXT(a_end_blocks, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready,
        "input ready right after end of message")

    // last digest word returns the block to idle
    `SHASH_ASSERT_NXT(a_last_idle, aclk, aresetn, m_tvalid && m_tready && m_tlast,
        s_tready && !m_tvalid, "no return to idle after last digest word")

    // no digest offered directly after a byte transfer
    `SHASH_ASSERT_NXT(a_no_early_out, aclk, aresetn, s_tvalid && s_tready, !m_tvalid,
        "digest offered before compression")

endmodule

`default_nettype wire
